/* design/hehom_pkg.sv */
// Package for the Hall-sensor homing sequencer.
// Holds the phase codes, register indexes, reset values and the raised-cosine table.
// No dependencies; every other design file apart from hehom_in_if imports it.
package hehom_pkg;

  localparam int unsigned FREQ_W    = 16;
  localparam int unsigned WIN_W     = 16;
  localparam int unsigned DEB_W     = 4;
  localparam int unsigned PHASE_W   = 4;
  localparam int unsigned RIDX_W    = 6;
  localparam int unsigned RSUB_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned S_W       = 16;
  localparam int unsigned RAMP_TAB_N = 1 << RIDX_W;

  localparam int unsigned RAMP_STEPS_DEF     = 24;
  localparam int unsigned TICKS_PER_POINT_DEF = 5;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 4'd2;
  localparam logic [WIN_W-1:0]  WINDOW_RST   = 16'd4000;
  localparam logic [FREQ_W-1:0] SEARCH_RST   = 16'd1000;
  localparam logic [FREQ_W-1:0] VERIFY_RST   = 16'd400;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE      = 4'd0,
    PH_CHK_EXIT  = 4'd1,
    PH_CHK_WIN   = 4'd2,
    PH_CHK_BACK  = 4'd3,
    PH_CHK_HOME  = 4'd4,
    PH_SEARCH    = 4'd5,
    PH_RAMP      = 4'd6,
    PH_VER_EXIT  = 4'd7,
    PH_VER_WIN   = 4'd8,
    PH_APPROACH  = 4'd9,
    PH_ESC_LEAVE = 4'd10,
    PH_ESC_FIND  = 4'd11,
    PH_ESC_PASS  = 4'd12,
    PH_DONE      = 4'd13
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_WINDOW   = 2'd1,
    CFG_SEARCH   = 2'd2,
    CFG_VERIFY   = 2'd3
  } cfg_idx_e;

  // Half-period raised cosine in Q15, 32 segments.
  localparam int unsigned COS_RAMP [33] = '{
    0, 79, 315, 705, 1247, 1935, 2761, 3719, 4799, 5990, 7282, 8661,
    10114, 11628, 13188, 14778, 16384, 17990, 19580, 21140, 22654, 24107,
    25486, 26778, 27969, 29049, 30007, 30833, 31521, 32063, 32453, 32689,
    32768
  };

endpackage

/* design/hehom_in_if.sv */
// Input channel of the homing sequencer: one millisecond tick per transaction.
// Has no dependencies.
interface hehom_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic hall_active;

  modport source (output valid, output start_req, output hall_active, input ready);
  modport sink (input valid, input start_req, input hall_active, output ready);
endinterface

/* design/hehom_out_if.sv */
// Result channel of the homing sequencer: motor commands and phase per transaction.
// Depends on hehom_pkg for the field widths.
interface hehom_out_if;
  import hehom_pkg::*;

  logic               valid;
  logic               ready;
  logic               motor_run;
  logic               direction;
  logic [FREQ_W-1:0]  step_freq_hz;
  logic               driver_enable;
  logic               led;
  logic               done_res;
  logic [PHASE_W-1:0] phase;

  modport source (output valid, output motor_run, output direction, output step_freq_hz,
                  output driver_enable, output led, output done_res, output phase,
                  input ready);
  modport sink (input valid, input motor_run, input direction, input step_freq_hz,
                input driver_enable, input led, input done_res, input phase,
                output ready);
endinterface

/* design/hall_endstop_aware_homing.sv */
// Top level of the Hall-sensor homing sequencer with endstop escape and cosine ramp.
// Depends on hehom_pkg, hehom_in_if and hehom_out_if.
//
//   Channel   Direction  Carries
//   in_i      sink       start_req, hall_active
//   out_o     source     motor_run, direction, step_freq_hz, driver_enable, led,
//                        done_res, phase
//   cfg_*     input      register index and 16-bit data, write only
//
// A transaction is taken into an input register, and the phase update and ramp rate
// are computed combinationally into the result register, which takes each result
// when free or read. A new tick can be taken every cycle while it is not stalled.
// The longest path is the 16 x 16 ramp multiplication. A stalled result register holds
// the input register, which takes one more tick only if empty. Reset returns to idle.
module hall_endstop_aware_homing #(
  parameter int unsigned RampSteps       = hehom_pkg::RAMP_STEPS_DEF,
  parameter int unsigned TicksPerRampPoint = hehom_pkg::TICKS_PER_POINT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  hehom_in_if.sink                         in_i,
  hehom_out_if.source                      out_o,
  input  logic                             cfg_we_i,
  input  logic [hehom_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hehom_pkg::CFG_W-1:0]      cfg_data_i
);
  import hehom_pkg::*;

  localparam int unsigned RSTEPS = (RampSteps < 1) ? 1 : RampSteps;
  localparam int unsigned RTICKS = (TicksPerRampPoint < 1) ? 1 : TicksPerRampPoint;

  logic [DEB_W-1:0]  deb_q;
  logic [WIN_W-1:0]  vwin_q;
  logic [FREQ_W-1:0] sfreq_q;
  logic [FREQ_W-1:0] vfreq_q;

  logic in_vq, start_q, hall_q;
  logic out_vq;
  logic advance;

  phase_e            ph_q, ph_d;
  logic              dir_q, dir_d;
  logic [DEB_W-1:0]  sc_q, sc_d;
  logic [WIN_W-1:0]  wt_q, wt_d;
  logic [RIDX_W-1:0] ri_q, ri_d;
  logic [RSUB_W-1:0] rs_q, rs_d;
  logic [FREQ_W-1:0] freq_q, freq_d;
  logic              side_q, side_d;
  logic              run_q, run_d, en_q, en_d, led_q, led_d;

  logic [DEB_W-1:0]  sc_inc;
  logic              hit_h, hit_nh;
  logic [DEB_W-1:0]  sc_h, sc_nh;
  logic [RSUB_W-1:0] rs_inc;
  logic              rs_wrap, ramp_end;
  logic              win_end;

  logic [S_W-1:0]      s_tab [RAMP_TAB_N];
  logic [RIDX_W-1:0]   ramp_sel;
  logic                up;
  logic [FREQ_W-1:0]   ramp_d;
  logic [2*S_W-1:0]    ramp_prod;
  logic [FREQ_W-1:0]   ramp_rnd;
  logic [FREQ_W-1:0]   ramp_f;

  // Ramp shape per ramp index, interpolated from the cosine table at elaboration.
  for (genvar g = 0; g < RAMP_TAB_N; g++) begin : g_ramp
    localparam int unsigned P    = (g * 8192) / RSTEPS;
    localparam int unsigned IDX  = P >> 8;
    localparam int unsigned FRAC = P & 255;
    localparam int unsigned LO   = (IDX >= 32) ? 31 : IDX;
    localparam int unsigned S    = (IDX >= 32) ? 32768 :
        COS_RAMP[LO] + (((COS_RAMP[LO+1] - COS_RAMP[LO]) * FRAC) >> 8);
    assign s_tab[g] = S_W'(S);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q   <= DEBOUNCE_RST;
      vwin_q  <= WINDOW_RST;
      sfreq_q <= SEARCH_RST;
      vfreq_q <= VERIFY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE: deb_q   <= cfg_data_i[DEB_W-1:0];
        CFG_WINDOW:   vwin_q  <= cfg_data_i[WIN_W-1:0];
        CFG_SEARCH:   sfreq_q <= cfg_data_i[FREQ_W-1:0];
        CFG_VERIFY:   vfreq_q <= cfg_data_i[FREQ_W-1:0];
      endcase
    end
  end

  assign advance  = in_vq && (!out_vq || out_o.ready);
  assign in_i.ready = !in_vq || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_i.ready) begin
      in_vq <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      start_q <= in_i.start_req;
      hall_q  <= in_i.hall_active;
    end
  end

  assign sc_inc  = sc_q + DEB_W'(1);
  assign hit_h   = hall_q && (sc_inc >= deb_q);
  assign hit_nh  = !hall_q && (sc_inc >= deb_q);
  assign sc_h    = (hall_q && !hit_h) ? sc_inc : '0;
  assign sc_nh   = (!hall_q && !hit_nh) ? sc_inc : '0;
  assign rs_inc  = rs_q + RSUB_W'(1);
  assign rs_wrap = rs_inc >= RSUB_W'(RTICKS);
  assign ramp_end = ri_q >= RIDX_W'(RSTEPS);
  assign win_end = wt_q >= vwin_q;

  always_comb begin
    if (ph_q != PH_RAMP) begin
      ramp_sel = '0;
    end else if (rs_wrap && !ramp_end) begin
      ramp_sel = ri_q + RIDX_W'(1);
    end else begin
      ramp_sel = ri_q;
    end
  end

  assign up        = vfreq_q >= sfreq_q;
  assign ramp_d    = up ? (vfreq_q - sfreq_q) : (sfreq_q - vfreq_q);
  assign ramp_prod = ramp_d * s_tab[ramp_sel];
  assign ramp_rnd  = FREQ_W'((ramp_prod + (2*S_W)'(16384)) >> 15);
  assign ramp_f    = up ? (sfreq_q + ramp_rnd) : (sfreq_q - ramp_rnd);

  always_comb begin
    ph_d   = ph_q;
    dir_d  = dir_q;
    sc_d   = sc_q;
    wt_d   = wt_q;
    ri_d   = ri_q;
    rs_d   = rs_q;
    freq_d = freq_q;
    side_d = side_q;
    run_d  = run_q;
    en_d   = en_q;
    led_d  = led_q;
    unique case (ph_q)
      PH_IDLE, PH_DONE: begin
        if (start_q) begin
          en_d   = 1'b1;
          led_d  = 1'b0;
          dir_d  = 1'b1;
          side_d = 1'b0;
          sc_d   = '0;
          wt_d   = '0;
          run_d  = 1'b1;
          if (hall_q) begin
            freq_d = vfreq_q;
            ph_d   = PH_CHK_EXIT;
          end else begin
            freq_d = sfreq_q;
            ph_d   = PH_SEARCH;
          end
        end
      end
      PH_CHK_EXIT: begin
        sc_d = sc_nh;
        if (hit_nh) begin
          wt_d = '0;
          ph_d = PH_CHK_WIN;
        end
      end
      PH_CHK_WIN: begin
        sc_d = sc_h;
        if (hit_h) begin
          dir_d  = side_q;
          led_d  = 1'b1;
          freq_d = sfreq_q;
          run_d  = 1'b1;
          ph_d   = PH_ESC_LEAVE;
        end else if (win_end) begin
          sc_d  = '0;
          run_d = 1'b1;
          if (!side_q) begin
            dir_d = 1'b0;
            ph_d  = PH_CHK_BACK;
          end else begin
            dir_d = 1'b1;
            ph_d  = PH_CHK_HOME;
          end
        end else begin
          wt_d = wt_q + WIN_W'(1);
        end
      end
      PH_CHK_BACK: begin
        sc_d = sc_h;
        if (hit_h) begin
          side_d = 1'b1;
          wt_d   = '0;
          freq_d = vfreq_q;
          run_d  = 1'b1;
          ph_d   = PH_CHK_EXIT;
        end
      end
      PH_CHK_HOME, PH_APPROACH: begin
        sc_d = sc_h;
        if (hit_h) begin
          run_d = 1'b0;
          en_d  = 1'b0;
          led_d = 1'b1;
          ph_d  = PH_DONE;
        end
      end
      PH_SEARCH: begin
        sc_d = sc_h;
        if (hit_h) begin
          if (vfreq_q == sfreq_q) begin
            wt_d   = '0;
            freq_d = vfreq_q;
            run_d  = 1'b1;
            ph_d   = PH_VER_EXIT;
          end else begin
            ri_d   = '0;
            rs_d   = '0;
            freq_d = ramp_f;
            ph_d   = PH_RAMP;
          end
        end
      end
      PH_RAMP: begin
        if (rs_wrap) begin
          rs_d = '0;
          if (ramp_end) begin
            sc_d   = '0;
            wt_d   = '0;
            freq_d = vfreq_q;
            run_d  = 1'b1;
            ph_d   = hall_q ? PH_VER_EXIT : PH_VER_WIN;
          end else begin
            ri_d   = ri_q + RIDX_W'(1);
            freq_d = ramp_f;
          end
        end else begin
          rs_d   = rs_inc;
          freq_d = ramp_f;
        end
      end
      PH_VER_EXIT: begin
        sc_d = sc_nh;
        if (hit_nh) begin
          wt_d = '0;
          ph_d = PH_VER_WIN;
        end
      end
      PH_VER_WIN: begin
        sc_d = sc_h;
        if (hit_h) begin
          dir_d  = !dir_q;
          led_d  = 1'b1;
          freq_d = sfreq_q;
          run_d  = 1'b1;
          ph_d   = PH_ESC_LEAVE;
        end else if (win_end) begin
          dir_d  = !dir_q;
          freq_d = vfreq_q;
          run_d  = 1'b1;
          sc_d   = '0;
          ph_d   = PH_APPROACH;
        end else begin
          wt_d = wt_q + WIN_W'(1);
        end
      end
      PH_ESC_LEAVE: begin
        sc_d = sc_nh;
        if (hit_nh) begin
          ph_d = PH_ESC_FIND;
        end
      end
      PH_ESC_FIND: begin
        sc_d = sc_h;
        if (hit_h) begin
          ph_d = PH_ESC_PASS;
        end
      end
      PH_ESC_PASS: begin
        sc_d = sc_nh;
        if (hit_nh) begin
          led_d  = 1'b0;
          freq_d = sfreq_q;
          run_d  = 1'b1;
          ph_d   = PH_SEARCH;
        end
      end
      default: begin
        ph_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      dir_q  <= 1'b1;
      sc_q   <= '0;
      wt_q   <= '0;
      ri_q   <= '0;
      rs_q   <= '0;
      freq_q <= SEARCH_RST;
      side_q <= 1'b0;
      run_q  <= 1'b0;
      en_q   <= 1'b0;
      led_q  <= 1'b0;
    end else if (advance) begin
      ph_q   <= ph_d;
      dir_q  <= dir_d;
      sc_q   <= sc_d;
      wt_q   <= wt_d;
      ri_q   <= ri_d;
      rs_q   <= rs_d;
      freq_q <= freq_d;
      side_q <= side_d;
      run_q  <= run_d;
      en_q   <= en_d;
      led_q  <= led_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (advance) begin
      out_vq <= 1'b1;
    end else if (out_o.ready) begin
      out_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_o.motor_run     <= run_d;
      out_o.direction     <= dir_d;
      out_o.step_freq_hz  <= (freq_d == '0) ? FREQ_W'(1) : freq_d;
      out_o.driver_enable <= en_d;
      out_o.led           <= led_d;
      out_o.done_res      <= ph_d == PH_DONE;
      out_o.phase         <= ph_d;
    end
  end

  assign out_o.valid = out_vq;

  a_done_stopped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq && out_o.done_res |-> !out_o.motor_run && !out_o.driver_enable && out_o.led)
    else $error("done result with the motor still running");

  a_ramp_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PH_RAMP |-> ri_q <= RIDX_W'(RSTEPS) && rs_q < RSUB_W'(RTICKS))
    else $error("ramp counters out of range");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vq)
    else $error("processed tick produced no result");

  a_freq_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq |-> out_o.step_freq_hz != '0)
    else $error("zero step rate on the result channel");

endmodule

/* verif/homing_cmd_checker.sv */
// Checker for the Hall-sensor homing sequencer: predicts the command of each tick and
// compares it with what the block returns. Depends on hehom_pkg, hehom_in_if and
// hehom_out_if; it follows configuration writes on the plain register port.
module homing_cmd_checker
  import hehom_pkg::*;
#(
  parameter int unsigned RampSteps         = RAMP_STEPS_DEF,
  parameter int unsigned TicksPerRampPoint = TICKS_PER_POINT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hehom_in_if                  tick_ch,
  hehom_out_if                 cmd_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int unsigned          mismatch_cnt_o,
  output int unsigned          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RSTEPS = (RampSteps < 1) ? 1 : RampSteps;
  localparam int unsigned RTICKS = (TicksPerRampPoint < 1) ? 1 : TicksPerRampPoint;

  typedef struct packed {
    logic              run;
    logic              dir;
    logic [FREQ_W-1:0] freq;
    logic              en;
    logic              led;
    logic              done;
    phase_e            ph;
  } motor_cmd_t;

  typedef enum logic [1:0] {
    WIN_OPEN,
    WIN_ENDSTOP,
    WIN_HOME
  } win_verdict_e;

  logic [DEB_W-1:0]  deb_need;
  logic [WIN_W-1:0]  win_len;
  logic [FREQ_W-1:0] search_hz;
  logic [FREQ_W-1:0] verify_hz;

  phase_e            ph;
  logic              dir;
  logic [DEB_W-1:0]  stable_cnt;
  logic [WIN_W-1:0]  win_tmr;
  logic [RIDX_W-1:0] ramp_idx;
  logic [RSUB_W-1:0] ramp_sub;
  logic [FREQ_W-1:0] freq;
  logic              second_side;
  logic              run;
  logic              en;
  logic              led;

  motor_cmd_t  expected_cmds [$];
  int unsigned failed_cmds;

  function automatic logic hall_settled(logic match);
    if (!match) begin
      stable_cnt = '0;
      return 1'b0;
    end
    stable_cnt = stable_cnt + 1'b1;
    if (stable_cnt >= deb_need) begin
      stable_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [FREQ_W-1:0] ramp_rate(int unsigned point);
    int unsigned     pos;
    int unsigned     seg;
    int unsigned     frac;
    int unsigned     shape;
    longint unsigned span;
    longint unsigned scaled;
    pos  = (point * 8192) / RSTEPS;
    seg  = pos >> 8;
    frac = pos & 255;
    if (seg >= 32) begin
      shape = 32768;
    end else begin
      shape = COS_RAMP[seg] + (((COS_RAMP[seg+1] - COS_RAMP[seg]) * frac) >> 8);
    end
    if (verify_hz >= search_hz) begin
      span   = verify_hz - search_hz;
      scaled = (span * shape + 16384) >> 15;
      return search_hz + scaled[FREQ_W-1:0];
    end
    span   = search_hz - verify_hz;
    scaled = (span * shape + 16384) >> 15;
    return search_hz - scaled[FREQ_W-1:0];
  endfunction

  function automatic void enter_verify(logic hall, phase_e exit_ph, phase_e win_ph);
    stable_cnt = '0;
    win_tmr    = '0;
    freq       = verify_hz;
    run        = 1'b1;
    ph         = hall ? exit_ph : win_ph;
  endfunction

  function automatic void enter_escape();
    led        = 1'b1;
    dir        = ~dir;
    freq       = search_hz;
    run        = 1'b1;
    stable_cnt = '0;
    ph         = PH_ESC_LEAVE;
  endfunction

  function automatic void enter_done();
    run = 1'b0;
    en  = 1'b0;
    led = 1'b1;
    ph  = PH_DONE;
  endfunction

  function automatic win_verdict_e window_step(logic hall);
    if (hall_settled(hall)) return WIN_ENDSTOP;
    if (win_tmr >= win_len) return WIN_HOME;
    win_tmr = win_tmr + 1'b1;
    return WIN_OPEN;
  endfunction

  function automatic motor_cmd_t advance_homing_tick(logic start, logic hall);
    win_verdict_e verdict;
    logic         left_ramp;
    motor_cmd_t   cmd;
    left_ramp = 1'b0;
    case (ph)
      PH_IDLE, PH_DONE: begin
        if (start) begin
          en          = 1'b1;
          led         = 1'b0;
          dir         = 1'b1;
          second_side = 1'b0;
          stable_cnt  = '0;
          win_tmr     = '0;
          if (hall) begin
            enter_verify(1'b1, PH_CHK_EXIT, PH_CHK_WIN);
          end else begin
            freq = search_hz;
            run  = 1'b1;
            ph   = PH_SEARCH;
          end
        end
      end
      PH_CHK_EXIT: begin
        if (hall_settled(!hall)) begin
          win_tmr = '0;
          ph      = PH_CHK_WIN;
        end
      end
      PH_CHK_WIN: begin
        verdict = window_step(hall);
        if (verdict == WIN_ENDSTOP) begin
          dir = !second_side;
          enter_escape();
        end else if (verdict == WIN_HOME) begin
          stable_cnt = '0;
          run        = 1'b1;
          if (!second_side) begin
            dir = 1'b0;
            ph  = PH_CHK_BACK;
          end else begin
            dir = 1'b1;
            ph  = PH_CHK_HOME;
          end
        end
      end
      PH_CHK_BACK: begin
        if (hall_settled(hall)) begin
          second_side = 1'b1;
          enter_verify(hall, PH_CHK_EXIT, PH_CHK_WIN);
        end
      end
      PH_CHK_HOME: begin
        if (hall_settled(hall)) enter_done();
      end
      PH_SEARCH: begin
        if (hall_settled(hall)) begin
          if (verify_hz == search_hz) begin
            enter_verify(hall, PH_VER_EXIT, PH_VER_WIN);
          end else begin
            ramp_idx = '0;
            ramp_sub = '0;
            freq     = ramp_rate(0);
            ph       = PH_RAMP;
          end
        end
      end
      PH_RAMP: begin
        ramp_sub = ramp_sub + 1'b1;
        if (ramp_sub >= RTICKS) begin
          ramp_sub = '0;
          if (ramp_idx >= RSTEPS) begin
            enter_verify(hall, PH_VER_EXIT, PH_VER_WIN);
            left_ramp = 1'b1;
          end else begin
            ramp_idx = ramp_idx + 1'b1;
          end
        end
        if (!left_ramp) freq = ramp_rate(ramp_idx);
      end
      PH_VER_EXIT: begin
        if (hall_settled(!hall)) begin
          win_tmr = '0;
          ph      = PH_VER_WIN;
        end
      end
      PH_VER_WIN: begin
        verdict = window_step(hall);
        if (verdict == WIN_ENDSTOP) begin
          enter_escape();
        end else if (verdict == WIN_HOME) begin
          dir        = ~dir;
          freq       = verify_hz;
          run        = 1'b1;
          stable_cnt = '0;
          ph         = PH_APPROACH;
        end
      end
      PH_APPROACH: begin
        if (hall_settled(hall)) enter_done();
      end
      PH_ESC_LEAVE: begin
        if (hall_settled(!hall)) ph = PH_ESC_FIND;
      end
      PH_ESC_FIND: begin
        if (hall_settled(hall)) ph = PH_ESC_PASS;
      end
      PH_ESC_PASS: begin
        if (hall_settled(!hall)) begin
          led  = 1'b0;
          freq = search_hz;
          run  = 1'b1;
          ph   = PH_SEARCH;
        end
      end
      default: ph = PH_IDLE;
    endcase
    cmd.run  = run;
    cmd.dir  = dir;
    cmd.freq = (freq == '0) ? FREQ_W'(1) : freq;
    cmd.en   = en;
    cmd.led  = led;
    cmd.done = (ph == PH_DONE);
    cmd.ph   = ph;
    return cmd;
  endfunction

  function automatic bit field_differs(string name, logic [FREQ_W-1:0] want,
                                       logic [FREQ_W-1:0] seen);
    if (seen === want) return 1'b0;
    $display("%0t ns: %s expected %0d, got %0d", $time, name, want, seen);
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    motor_cmd_t want;
    bit         bad;
    if (!rst_ni) begin
      deb_need    = DEBOUNCE_RST;
      win_len     = WINDOW_RST;
      search_hz   = SEARCH_RST;
      verify_hz   = VERIFY_RST;
      ph          = PH_IDLE;
      dir         = 1'b1;
      stable_cnt  = '0;
      win_tmr     = '0;
      ramp_idx    = '0;
      ramp_sub    = '0;
      freq        = SEARCH_RST;
      second_side = 1'b0;
      run         = 1'b0;
      en          = 1'b0;
      led         = 1'b0;
      expected_cmds.delete();
      failed_cmds  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_DEBOUNCE: deb_need  = cfg_data_i[DEB_W-1:0];
          CFG_WINDOW:   win_len   = cfg_data_i[WIN_W-1:0];
          CFG_SEARCH:   search_hz = cfg_data_i[FREQ_W-1:0];
          CFG_VERIFY:   verify_hz = cfg_data_i[FREQ_W-1:0];
          default: ;
        endcase
      end
      if (tick_ch.valid && tick_ch.ready) begin
        expected_cmds.push_back(advance_homing_tick(tick_ch.start_req, tick_ch.hall_active));
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t ns: command transaction with no tick outstanding, phase %0d",
                   $time, cmd_ch.phase);
          failed_cmds++;
        end else begin
          want = expected_cmds.pop_front();
          bad  = field_differs("motor_run", want.run, cmd_ch.motor_run)
               | field_differs("direction", want.dir, cmd_ch.direction)
               | field_differs("step_freq_hz", want.freq, cmd_ch.step_freq_hz)
               | field_differs("driver_enable", want.en, cmd_ch.driver_enable)
               | field_differs("led", want.led, cmd_ch.led)
               | field_differs("done_res", want.done, cmd_ch.done_res)
               | field_differs("phase", want.ph, cmd_ch.phase);
          if (bad) failed_cmds++;
        end
      end
    end
    mismatch_cnt_o <= failed_cmds;
    outstanding_o  <= expected_cmds.size();
  end

endmodule

/* verif/tb_top.sv */
// Top of the homing sequencer testbench: clock, reset, configuration phases and tick
// stimulus with random gaps and stalls. Depends on hehom_pkg, both channel interfaces,
// the block itself and homing_cmd_checker, which predicts and compares.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hehom_pkg::*;

  // Each entry is {start_req, hall_active}.
  localparam bit [1:0] DIRECTED_TICKS [26] = '{
    2'b01, 2'b00, 2'b11, 2'b10, 2'b01, 2'b00, 2'b01, 2'b00, 2'b01, 2'b00,
    2'b00, 2'b00, 2'b00, 2'b01, 2'b11, 2'b00, 2'b00, 2'b00, 2'b00, 2'b01,
    2'b00, 2'b00, 2'b00, 2'b00, 2'b01, 2'b10
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  int unsigned          cmd_mismatches;
  int unsigned          cmds_outstanding;
  bit                   gaps_on;
  bit                   stalls_on;
  int                   stall_left = 0;

  hehom_in_if  tick_ch ();
  hehom_out_if cmd_ch ();

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  hall_endstop_aware_homing u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tick_ch),
    .out_o      (cmd_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  homing_cmd_checker u_cmd_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_ch        (tick_ch),
    .cmd_ch         (cmd_ch),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .mismatch_cnt_o (cmd_mismatches),
    .outstanding_o  (cmds_outstanding)
  );

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      cmd_ch.ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      stall_left   <= $urandom_range(0, 3);
      cmd_ch.ready <= 1'b0;
    end else begin
      cmd_ch.ready <= 1'b1;
    end
  end

  task automatic send_tick(bit start, bit hall);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    tick_ch.valid       <= 1'b1;
    tick_ch.start_req   <= start;
    tick_ch.hall_active <= hall;
    do @(posedge clk_i); while (!tick_ch.ready);
  endtask

  task automatic drain_ticks();
    tick_ch.valid <= 1'b0;
    do @(posedge clk_i); while (cmds_outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [DEB_W-1:0] deb, logic [WIN_W-1:0] win,
                           logic [FREQ_W-1:0] search, logic [FREQ_W-1:0] verify,
                           bit gaps, bit stalls);
    drain_ticks();
    write_reg(CFG_DEBOUNCE, CFG_W'(deb));
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_SEARCH, search);
    write_reg(CFG_VERIFY, verify);
    cfg_we    <= 1'b0;
    gaps_on   = gaps;
    stalls_on <= stalls;
  endtask

  // Hall level comes in runs: mostly long magnet passes, sometimes short chatter.
  task automatic run_hall_stream(int unsigned n_ticks);
    bit          level;
    int unsigned run_left;
    level    = 1'($urandom_range(0, 1));
    run_left = 0;
    repeat (n_ticks) begin
      if (run_left == 0) begin
        level    = ~level;
        run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
      end
      send_tick($urandom_range(0, 15) == 0, level);
      run_left--;
    end
  endtask

  initial begin
    int i;
    tick_ch.valid       <= 1'b0;
    tick_ch.start_req   <= 1'b0;
    tick_ch.hall_active <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_DEBOUNCE;
    cfg_data            <= '0;
    gaps_on             = 1'b0;
    stalls_on           <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(4'd1, 16'd2, 16'd1000, 16'd1000, 1'b0, 1'b0);
    for (i = 0; i < 26; i++) begin
      send_tick(DIRECTED_TICKS[i][1], DIRECTED_TICKS[i][0]);
    end

    configure(4'd2, 16'd40, 16'd1000, 16'd400, 1'b1, 1'b1);
    run_hall_stream(280);
    configure(4'd0, 16'd0, 16'd0, 16'd65535, 1'b1, 1'b0);
    run_hall_stream(280);
    configure(4'd15, 16'd65535, 16'd65535, 16'd1, 1'b0, 1'b1);
    run_hall_stream(280);
    configure(4'd1, 16'd25, 16'd500, 16'd500, 1'b1, 1'b1);
    run_hall_stream(280);
    configure(DEB_W'($urandom_range(1, 15)), WIN_W'($urandom_range(5, 80)),
              FREQ_W'($urandom_range(1, 65535)), FREQ_W'($urandom_range(1, 65535)),
              1'b1, 1'b1);
    run_hall_stream(280);
    configure(4'd4, 16'd30, 16'd300, 16'd2000, 1'b0, 1'b0);
    run_hall_stream(280);

    drain_ticks();
    if (cmd_mismatches == 0) begin
      $display("hall_endstop_aware_homing: match");
    end else begin
      $display("hall_endstop_aware_homing: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("hall_endstop_aware_homing: mismatch");
    $finish;
  end

endmodule
